// ----- hw/rtl/cgp_pkg.sv -----
package cgp_pkg;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_W   = 19;
  localparam int IDX_W   = 2;
  localparam int DIM_W   = 13;
  localparam int TIME_W  = 19;
  localparam int COORD_W = 12;
  localparam int COLOR_W = 8;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_TIME   = 2'd2;

  // Pi times 2^30, rounded.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

endpackage

// ----- hw/rtl/cgp_div_cell.sv -----
// One restoring-division step: compares the shifted remainder with the divisor
// and emits one quotient bit. Carries the rest of the pixel request alongside.
module cgp_div_cell #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 13,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DEN_W:0]    rem_in,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [NUM_W-1:0]  quo_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic [DEN_W:0]    rem_out,
  output logic [NUM_W-1:0]  num_out,
  output logic [NUM_W-1:0]  quo_out,
  output logic [DEN_W-1:0]  den_out,
  output logic [SIDE_W-1:0] side_out
);
  logic [DEN_W+1:0] trial;
  logic [DEN_W+1:0] diff;
  logic             fits;

  always_comb begin
    trial = {rem_in, num_in[NUM_W-1]};
    diff  = trial - {2'b00, den_in};
    fits  = (trial >= {2'b00, den_in});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= fits ? diff[DEN_W:0] : trial[DEN_W:0];
      num_out  <= {num_in[NUM_W-2:0], 1'b0};
      quo_out  <= {quo_in[NUM_W-2:0], fits};
      den_out  <= den_in;
      side_out <= side_in;
    end
  end
endmodule

// ----- hw/rtl/cgp_cos_cell.sv -----
// Color channel: phase reduction, a Horner cosine with a register after every
// multiply, and the final scale to eight bits.
module cgp_cos_cell #(
  parameter int FRAC_BITS = 16,
  parameter int P_W = 24
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [P_W-1:0]                phase,
  output logic [cgp_pkg::COLOR_W-1:0]   color
);
  import cgp_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam longint unsigned PI_L = (PI_Q30 + (64'd1 << (SH - 1))) >> SH;
  localparam int V_W = FRAC_BITS + 3;
  localparam logic [V_W-1:0] ONE     = V_W'(64'd1 << FRAC_BITS);
  localparam logic [V_W-1:0] PI_Q    = V_W'(PI_L);
  localparam logic [V_W-1:0] HALF_PI = V_W'(PI_L / 2);
  localparam logic [P_W-1:0] TWO_PI  = P_W'(PI_L * 2);
  localparam logic [P_W:0]   TWO_PI1 = (P_W+1)'(PI_L * 2);
  localparam logic [P_W:0]   FOUR_PI = (P_W+1)'(PI_L * 4);
  localparam int M_W = 2 * V_W;

  // Division by the Horner constants is a multiply by a rounded-up reciprocal.
  // Seven extra bits cover every divisor below 128, which keeps the quotient
  // exact for any V_W-bit dividend.
  localparam int RK   = V_W + 7;
  localparam int RP_W = V_W + RK;
  localparam logic [RK-1:0] R90 = RK'(((64'd1 << RK) + 64'd89) / 64'd90);
  localparam logic [RK-1:0] R56 = RK'(((64'd1 << RK) + 64'd55) / 64'd56);
  localparam logic [RK-1:0] R30 = RK'(((64'd1 << RK) + 64'd29) / 64'd30);
  localparam logic [RK-1:0] R12 = RK'(((64'd1 << RK) + 64'd11) / 64'd12);

  function automatic logic [V_W-1:0] div_by(input logic [V_W-1:0] n,
                                            input logic [RK-1:0] m);
    logic [RP_W-1:0] prod;
    prod = {{RK{1'b0}}, n} * {{V_W{1'b0}}, m};
    return V_W'(prod >> RK);
  endfunction

  // Stage 0: the phase stays below 4*2pi at most; fold by subtracting 4pi,
  // then 2pi.
  logic [P_W-1:0] p0, p0a;
  logic [P_W-1:0] p1;
  logic [V_W-1:0] p2;
  logic           neg2;
  logic [M_W-1:0] sq3;
  logic [V_W-1:0] s4;
  logic [M_W-1:0] m5, m7, m9, m11;
  logic [V_W-1:0] t5, t6, t8, t10;
  logic [V_W-1:0] s5, s6, s7, s8, s9, s10, s11;
  logic [10:0]    neg_sr;
  logic [V_W-1:0] q;
  logic [V_W:0]   w;
  logic [V_W+8:0] sc;

  always_comb begin
    p0a = ({1'b0, phase} >= FOUR_PI) ? P_W'({1'b0, phase} - FOUR_PI) : phase;
    p0  = ({1'b0, p0a} >= TWO_PI1) ? (p0a - TWO_PI) : p0a;
  end

  logic [V_W-1:0] p1r;
  logic [V_W-1:0] p1m;
  always_comb begin
    p1r = V_W'(p1);
    p1m = (p1r > PI_Q) ? V_W'(TWO_PI - p1) : p1r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= p0;
      p2  <= (p1m > HALF_PI) ? (PI_Q - p1m) : p1m;
      neg2 <= (p1m > HALF_PI);
      neg_sr <= {neg_sr[9:0], neg2};
      sq3 <= p2 * p2;
      s4  <= V_W'(sq3 >> FRAC_BITS);
      t5  <= ONE - div_by(s4, R90);
      s5  <= s4;
      m5  <= s5 * t5;           // s*t
      s6  <= s5;
      t6  <= ONE - div_by(V_W'(m5 >> FRAC_BITS), R56);
      s7  <= s6;
      m7  <= s7 * t6;
      s8  <= s7;
      t8  <= ONE - div_by(V_W'(m7 >> FRAC_BITS), R30);
      s9  <= s8;
      m9  <= s9 * t8;
      s10 <= s9;
      t10 <= ONE - div_by(V_W'(m9 >> FRAC_BITS), R12);
      s11 <= s10;
      m11 <= s11 * t10;
      q   <= V_W'((m11 >> FRAC_BITS) >> 1);
    end
  end

  // c = one - q saturated at zero, then scale and round.
  logic [V_W-1:0] c;
  always_comb begin
    c  = (q >= ONE) ? '0 : (ONE - q);
    w  = neg_sr[10] ? {1'b0, ONE - c} : ({1'b0, ONE} + {1'b0, c});
    sc = (V_W+9)'(w) * (V_W+9)'(255) + (V_W+9)'(ONE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color <= COLOR_W'(sc >> (FRAC_BITS + 1));
    end
  end
endmodule

// ----- hw/rtl/cosine_gradient_pixel_unit.sv -----
// Cosine gradient pixel unit. Each request carries a pixel coordinate and the
// result is the red, green and blue bytes of the cosine palette at phase
// time + x/width + 1 - y/height, with channel offsets of 0, 2 and 4 radians.
// The unit takes one request every clock cycle while the output is not stalled. The
// two divisions each run in a chain of restoring-division cells, one
// quotient bit per cell and FRAC_BITS+COORD_W cells deep, then the phase
// registers base and ph_r/ph_g/ph_b, and the fourteen-stage cosine chain; the
// whole pipe advances only when the output register is free or being taken, so
// back-pressure on the result stalls everything without losing a request.
// Width and height of zero read as one and values above MAX_DIM read as MAX_DIM;
// coordinates beyond the frame are clamped to the last row or column.
// Configuration must only be written while no request is in flight.
module cosine_gradient_pixel_unit #(
  parameter int MAX_DIM   = cgp_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = cgp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cgp_pkg::IDX_W-1:0]      cfg_index,
  input  logic [cgp_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cgp_pkg::COORD_W-1:0]    pixel_x,
  input  logic [cgp_pkg::COORD_W-1:0]    pixel_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cgp_pkg::COLOR_W-1:0]    red,
  output logic [cgp_pkg::COLOR_W-1:0]    green,
  output logic [cgp_pkg::COLOR_W-1:0]    blue
);
  import cgp_pkg::*;

  localparam int NUM_W   = COORD_W + FRAC_BITS;
  localparam int NCELL   = NUM_W;
  localparam int COS_LAT = 14;
  localparam int LAT     = NCELL + 2 + COS_LAT;
  localparam int P_W     = FRAC_BITS + 6;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_DIM > 8191 ? 8191 : MAX_DIM);

  logic [DIM_W-1:0]  frame_width, frame_height;
  logic [TIME_W-1:0] time_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(255);
      frame_height <= DIM_W'(255);
      time_phase   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_TIME:   time_phase   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective divisors and time in Q.FRAC_BITS.
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [P_W-1:0]   time_q;
  always_comb begin
    w_eff = (frame_width == '0) ? DIM_W'(1) : (frame_width > MAXD ? MAXD : frame_width);
    h_eff = (frame_height == '0) ? DIM_W'(1) : (frame_height > MAXD ? MAXD : frame_height);
    if (FRAC_BITS >= 16) time_q = P_W'({3'b0, time_phase} << (FRAC_BITS - 16));
    else                 time_q = P_W'({3'b0, time_phase} >> (16 - FRAC_BITS));
  end

  // Pipe control: valid bit per stage, advance when the output slot frees.
  logic          en;
  logic [LAT-1:0] vld;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  logic [COORD_W-1:0] xc, yc;
  always_comb begin
    xc = ({1'b0, pixel_x} >= w_eff) ? COORD_W'(w_eff - 1'b1) : pixel_x;
    yc = ({1'b0, pixel_y} >= h_eff) ? COORD_W'(h_eff - 1'b1) : pixel_y;
  end

  // Two chains of division cells; neither chain carries anything extra.
  logic [DIM_W:0]   rx [NCELL+1], ry [NCELL+1];
  logic [NUM_W-1:0] nx [NCELL+1], ny [NCELL+1];
  logic [NUM_W-1:0] qx [NCELL+1], qy [NCELL+1];
  logic [DIM_W-1:0] dx [NCELL+1], dy [NCELL+1];
  logic [0:0]       sx [NCELL+1], sy [NCELL+1];

  assign rx[0] = '0;
  assign ry[0] = '0;
  assign nx[0] = {xc, FRAC_BITS'(0)};
  assign ny[0] = {yc, FRAC_BITS'(0)};
  assign qx[0] = '0;
  assign qy[0] = '0;
  assign dx[0] = w_eff;
  assign dy[0] = h_eff;
  assign sx[0] = 1'b0;
  assign sy[0] = 1'b0;

  for (genvar i = 0; i < NCELL; i++) begin : g_div
    cgp_div_cell #(.NUM_W(NUM_W), .DEN_W(DIM_W), .SIDE_W(1)) u_x (
      .clk, .en, .rem_in(rx[i]), .num_in(nx[i]), .quo_in(qx[i]), .den_in(dx[i]),
      .side_in(sx[i]), .rem_out(rx[i+1]), .num_out(nx[i+1]), .quo_out(qx[i+1]),
      .den_out(dx[i+1]), .side_out(sx[i+1])
    );
    cgp_div_cell #(.NUM_W(NUM_W), .DEN_W(DIM_W), .SIDE_W(1)) u_y (
      .clk, .en, .rem_in(ry[i]), .num_in(ny[i]), .quo_in(qy[i]), .den_in(dy[i]),
      .side_in(sy[i]), .rem_out(ry[i+1]), .num_out(ny[i+1]), .quo_out(qy[i+1]),
      .den_out(dy[i+1]), .side_out(sy[i+1])
    );
  end

  // Quotients are below one; phase = time + u + one - v (+2, +4 radians).
  localparam logic [P_W-1:0] ONE_P = P_W'(1) << FRAC_BITS;
  logic [P_W-1:0] base, ph_r, ph_g, ph_b;
  always_ff @(posedge clk) begin
    if (en) begin
      base <= time_q + P_W'(qx[NCELL][Q_W-1:0]) + ONE_P - P_W'(qy[NCELL][Q_W-1:0]);
      ph_r <= base;
      ph_g <= base + (ONE_P << 1);
      ph_b <= base + (ONE_P << 2);
    end
  end

  cgp_cos_cell #(.FRAC_BITS(FRAC_BITS), .P_W(P_W)) u_r (
    .clk, .en, .phase(ph_r), .color(red));
  cgp_cos_cell #(.FRAC_BITS(FRAC_BITS), .P_W(P_W)) u_g (
    .clk, .en, .phase(ph_g), .color(green));
  cgp_cos_cell #(.FRAC_BITS(FRAC_BITS), .P_W(P_W)) u_b (
    .clk, .en, .phase(ph_b), .color(blue));

endmodule

// ----- tb/cgp_checker.sv -----
module cgp_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cgp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cgp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [cgp_pkg::COORD_W-1:0] pixel_x,
  input  logic [cgp_pkg::COORD_W-1:0] pixel_y,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [cgp_pkg::COLOR_W-1:0] red,
  input  logic [cgp_pkg::COLOR_W-1:0] green,
  input  logic [cgp_pkg::COLOR_W-1:0] blue,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cgp_pkg::*;

  localparam int F = FRAC_BITS_DEF;
  localparam longint unsigned ONE = 64'd1 << F;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [TIME_W-1:0] time_q;
  rgb_t              colors_due[$];

  function automatic logic [COLOR_W-1:0] palette_byte(longint unsigned p);
    longint unsigned pi_q, two_pi, half_pi, s, t, prod, c, w;
    bit neg;
    pi_q = (PI_Q30 + (64'd1 << (29 - F))) >> (30 - F);
    two_pi = 2 * pi_q;
    half_pi = pi_q / 2;
    neg = 0;
    while (p >= two_pi) p -= two_pi;
    if (p > pi_q) p = two_pi - p;
    if (p > half_pi) begin
      neg = 1;
      p = pi_q - p;
    end
    s = (p * p) >> F;
    t = ONE - s / 90;
    t = ONE - ((s * t) >> F) / 56;
    t = ONE - ((s * t) >> F) / 30;
    t = ONE - ((s * t) >> F) / 12;
    prod = ((s * t) >> F) / 2;
    c = (prod >= ONE) ? 0 : ONE - prod;
    w = neg ? ONE - c : ONE + c;
    return COLOR_W'((255 * w + ONE) >> (F + 1));
  endfunction

  function automatic longint unsigned clamp_size(longint unsigned d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return d;
  endfunction

  function automatic rgb_t shade_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    longint unsigned w, h, x, y, base;
    rgb_t res;
    w = clamp_size(width_q);
    h = clamp_size(height_q);
    x = px;
    y = py;
    if (x >= w) x = w - 1;
    if (y >= h) y = h - 1;
    base = (longint'(time_q) << (F - 16)) + (x << F) / w + ONE - (y << F) / h;
    res.r = palette_byte(base);
    res.g = palette_byte(base + 2 * ONE);
    res.b = palette_byte(base + 4 * ONE);
    return res;
  endfunction

  assign pending = colors_due.size();

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      width_q <= 13'd255;
      height_q <= 13'd255;
      time_q <= '0;
      errors <= 0;
    end else begin
      if (in_valid && in_ready) colors_due.push_back(shade_pixel(pixel_x, pixel_y));
      if (out_valid && out_ready) begin
        if (colors_due.size() == 0) begin
          if (errors < 10) $display("unexpected result r=%0d g=%0d b=%0d", red, green, blue);
          errors <= errors + 1;
        end else begin
          want = colors_due.pop_front();
          if (want.r !== red || want.g !== green || want.b !== blue) begin
            if (errors < 10)
              $display("color mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       want.r, want.g, want.b, red, green, blue);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH: begin
            width_q <= cfg_data[DIM_W-1:0];
          end
          REG_HEIGHT: begin
            height_q <= cfg_data[DIM_W-1:0];
          end
          REG_TIME: begin
            time_q <= cfg_data[TIME_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cgp_pkg::*;

  // Idle patterns per phase: free running, sender idle, receiver stall, both.
  typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SQUEEZE_CYCLES = 300;
  // Drain after the last result for longer than the pipe is deep.
  localparam int DRAIN_CYCLES = 120;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [COORD_W-1:0] pixel_x = '0;
  logic [COORD_W-1:0] pixel_y = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [COLOR_W-1:0] red, green, blue;
  int                 errors, pending;

  flow_t flow = FLOW_FREE;
  bit    squeeze_armed = 0;
  int    stall_count = 0;
  int    quiet_cycles = 0;
  int    cur_w = 255, cur_h = 255;

  always #1 clk = ~clk;

  cosine_gradient_pixel_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_ready(out_ready), .red(red), .green(green), .blue(blue)
  );

  cgp_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_ready(out_ready), .red(red), .green(green), .blue(blue),
    .errors(errors), .pending(pending)
  );

  // The receiver draws its ready each cycle. Once the squeeze is armed it
  // holds ready low for a long stretch so the pipe backs up to the input.
  always @(posedge clk) begin
    if (squeeze_armed && stall_count == 0) begin
      stall_count <= SQUEEZE_CYCLES;
      out_ready <= 0;
    end else if (stall_count > 1) begin
      stall_count <= stall_count - 1;
      out_ready <= 0;
    end else begin
      if (stall_count == 1 && !squeeze_armed) stall_count <= 0;
      if (flow == FLOW_RECV_STALL || flow == FLOW_BOTH)
        out_ready <= ($urandom_range(99) >= 73);
      else
        out_ready <= 1;
    end
  end

  // Watchdog: cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one pixel request; returns at the edge where it is accepted. The
  // ready seen at the falling edge is the one that counts at the next rise.
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    bit taken;
    int gap;
    gap = 0;
    if (flow == FLOW_SEND_IDLE || flow == FLOW_BOTH)
      while ($urandom_range(99) < 73 && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    pixel_x <= x;
    pixel_y <= y;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
  endtask

  // Wait until every prediction has been matched; write_sizes calls it first.
  task automatic wait_drained();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_sizes(input int w, input int h, input int t);
    wait_drained();
    cfg_we <= 1;
    cfg_index <= REG_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk);
    cfg_index <= REG_TIME;
    cfg_data <= CFG_W'(t);
    @(posedge clk);
    // An index past the last register must change nothing.
    cfg_index <= IDX_W'(3);
    cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    cur_w = (w == 0) ? 1 : (w > MAX_DIM_DEF ? MAX_DIM_DEF : w);
    cur_h = (h == 0) ? 1 : (h > MAX_DIM_DEF ? MAX_DIM_DEF : h);
  endtask

  // Mostly coordinates inside the frame, some anywhere in the field range.
  task automatic random_pixel();
    logic [COORD_W-1:0] x, y;
    if ($urandom_range(3) == 0) begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end else begin
      x = COORD_W'($urandom_range(cur_w - 1));
      y = COORD_W'($urandom_range(cur_h - 1));
    end
    send_pixel(x, y);
  endtask

  int sizes_w[8] = '{255, 1, 4096, 0, 8191, 640, 3, 1000};
  int sizes_h[8] = '{255, 1, 4096, 0, 8191, 480, 2, 4095};
  int times[8]   = '{0, 411774, 0, 205887, 411774, 1234, 300000, 524287};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: corner coordinates at default and extreme sizes, including
    // sizes of zero and above the maximum and coordinates beyond the frame.
    for (int k = 0; k < 5; k++) begin
      write_sizes(sizes_w[k], sizes_h[k], times[k]);
      send_pixel(0, 0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'hFFF, 0);
      send_pixel(0, 12'hFFF);
      send_pixel(12'hAAA, 12'h555);
    end

    // Random phases, each with its own setting and one of the four idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 5) write_sizes(sizes_w[ph + 3], sizes_h[ph + 3], times[ph + 3]);
      else write_sizes($urandom_range(8191), $urandom_range(8191), $urandom_range(524287));
      flow = flow_t'(ph % 4);
      for (int n = 0; n < 115; n++) begin
        if (ph == 4 && n == 10) squeeze_armed = 1;
        if (ph == 4 && n == 11) squeeze_armed = 0;
        random_pixel();
      end
    end

    in_valid <= 0;
    flow = FLOW_FREE;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
